// ===== rtl/mbms_pkg.sv =====
// Package for the metaball marching-squares cell block.
// Holds widths, register reset values, the payload words and the fill pattern table.
// No dependencies.
package mbms_pkg;

  localparam int unsigned CELL_DEF       = 5;
  localparam int unsigned IMAGE_SIZE_DEF = 512;

  localparam int unsigned ROW_W     = 10;   // input coordinate width
  localparam int unsigned CRD_W     = 11;   // corner coordinate, row + CELL
  localparam int unsigned IMG_W     = 12;   // pixel bound compare width
  localparam int unsigned REG_W     = 12;   // ball center register width
  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned NUM_BALLS = 3;
  localparam int unsigned NUM_CRN   = 4;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned MASK_W    = 25;

  localparam int unsigned DIFF_W    = 14;   // signed corner-to-center difference
  localparam int unsigned DSQ_W     = 26;   // squared distance
  localparam int unsigned FX_SHIFT  = 32;   // radius^2 scaled by 2^32
  localparam int unsigned LIM_W     = 44;   // radius^2 << 32, also quotient width
  localparam int unsigned ROOT_W    = 22;   // weight width
  localparam int unsigned WSUM_W    = 24;   // sum of three weights
  localparam int unsigned LANE_LAT  = 3 + LIM_W + ROOT_W;

  localparam logic [WSUM_W-1:0] ONE_FX = WSUM_W'(65536);

  localparam int unsigned BALL_RADIUS [NUM_BALLS] = '{50, 30, 20};

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] =
    '{12'd223, 12'd148, 12'd45, 12'd430, 12'd450, 12'd450};

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [ROW_W-1:0] cell_col;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] corner_inside;
    logic [MASK_W-1:0] fill_mask;
  } out_word_t;

  // Marching-squares fill pattern: pixel (x, y) of a cell of side s, h = s/2.
  function automatic logic paint(logic [CODE_W-1:0] code, int x, int y, int s, int h);
    logic p;
    case (code)
      4'd15:   p = 1'b1;
      4'd14:   p = x < h + s - y;
      4'd13:   p = x <= y + h;
      4'd12:   p = x < h;
      4'd11:   p = h + x > y;
      4'd10:   p = y < h;
      4'd9:    p = (x > h + s - y) || (h - x > y);
      4'd8:    p = h - x >= y;
      4'd7:    p = h - x < y;
      4'd6:    p = (x > y + h) || (h + x < y);
      4'd5:    p = y >= h;
      4'd4:    p = h + x <= y;
      4'd3:    p = x >= h;
      4'd2:    p = x > y + h;
      4'd1:    p = x >= h + s - y;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/mbms_lane.sv =====
// One corner/ball weight lane: distance squared, restoring divide, then square root.
// Fully pipelined, one stage per quotient or root bit. Depends on mbms_pkg.
module mbms_lane import mbms_pkg::*; #(
  parameter int unsigned RADIUS = 50
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [CRD_W-1:0]        row_i,
  input  logic [CRD_W-1:0]        col_i,
  input  logic signed [REG_W-1:0] ctr_row_i,
  input  logic signed [REG_W-1:0] ctr_col_i,
  output logic                    zero_o,
  output logic [ROOT_W-1:0]       weight_o
);

  localparam logic [LIM_W-1:0] LIM = LIM_W'(RADIUS * RADIUS) << FX_SHIFT;

  logic signed [DIFF_W-1:0]   row_s, col_s, dr_q, dc_q;
  logic signed [2*DIFF_W-1:0] sqr_r_d, sqr_c_d;
  logic [2*DIFF_W-1:0]        sqr_r_q, sqr_c_q;
  logic [DSQ_W-1:0]           dsq_q;

  assign row_s   = signed'(DIFF_W'(row_i));
  assign col_s   = signed'(DIFF_W'(col_i));
  assign sqr_r_d = dr_q * dr_q;
  assign sqr_c_d = dc_q * dc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q    <= row_s - DIFF_W'(ctr_row_i);
      dc_q    <= col_s - DIFF_W'(ctr_col_i);
      sqr_r_q <= unsigned'(sqr_r_d);
      sqr_c_q <= unsigned'(sqr_c_d);
      dsq_q   <= DSQ_W'(sqr_r_q) + DSQ_W'(sqr_c_q);
    end
  end

  // restoring divide of the constant LIM by dsq, MSB first
  logic [DSQ_W-1:0] dv_d_q   [LIM_W];
  logic [DSQ_W-1:0] dv_rem_q [LIM_W];
  logic [LIM_W-1:0] dv_quo_q [LIM_W];
  logic             dv_zero_q[LIM_W];

  for (genvar k = 0; k < LIM_W; k++) begin : g_div
    logic [DSQ_W-1:0] d_in, rem_in;
    logic [LIM_W-1:0] quo_in;
    logic             z_in, take;
    logic [DSQ_W:0]   t;
    if (k == 0) begin : g_first
      assign d_in   = dsq_q;
      assign rem_in = '0;
      assign quo_in = '0;
      assign z_in   = (dsq_q == '0);
    end else begin : g_next
      assign d_in   = dv_d_q[k-1];
      assign rem_in = dv_rem_q[k-1];
      assign quo_in = dv_quo_q[k-1];
      assign z_in   = dv_zero_q[k-1];
    end
    assign t    = {rem_in, LIM[LIM_W-1-k]};
    assign take = (t >= {1'b0, d_in});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_d_q[k]    <= d_in;
        dv_rem_q[k]  <= take ? DSQ_W'(t - {1'b0, d_in}) : DSQ_W'(t);
        dv_quo_q[k]  <= {quo_in[LIM_W-2:0], take};
        dv_zero_q[k] <= z_in;
      end
    end
  end

  // digit-by-digit square root of the quotient, two radicand bits a stage
  logic [LIM_W-1:0]  sq_n_q   [ROOT_W];
  logic [ROOT_W+1:0] sq_rem_q [ROOT_W];
  logic [ROOT_W-1:0] sq_root_q[ROOT_W];
  logic              sq_zero_q[ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [LIM_W-1:0]  n_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              z_in, take;
    logic [ROOT_W+3:0] t, trial;
    if (k == 0) begin : g_first
      assign n_in    = dv_quo_q[LIM_W-1];
      assign rem_in  = '0;
      assign root_in = '0;
      assign z_in    = dv_zero_q[LIM_W-1];
    end else begin : g_next
      assign n_in    = sq_n_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign z_in    = sq_zero_q[k-1];
    end
    assign t     = {rem_in, n_in[LIM_W-1 -: 2]};
    assign trial = (ROOT_W+4)'({root_in, 2'b01});
    assign take  = (t >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_n_q[k]    <= n_in << 2;
        sq_rem_q[k]  <= take ? (ROOT_W+2)'(t - trial) : (ROOT_W+2)'(t);
        sq_root_q[k] <= {root_in[ROOT_W-2:0], take};
        sq_zero_q[k] <= z_in;
      end
    end
  end

  assign weight_o = sq_root_q[ROOT_W-1];
  assign zero_o   = sq_zero_q[ROOT_W-1];

endmodule

// ===== rtl/metaball_marching_squares_cell_top.sv =====
// Top level of the metaball marching-squares cell block: config registers,
// twelve weight lanes, corner decision and fill mask stages. Depends on mbms_pkg, mbms_lane.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_stall_o | in_word_t  (cell_row, cell_col)
//  out     | output    | out_valid_o/out_stall_i | out_word_t (corner_inside, fill_mask)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One cell word per clock while the output is not stalled. The pipeline is
// 3 distance stages, 44 divider stages (one quotient bit each), 22 root stages
// (one root bit each), a weight-sum/compare stage and the mask/output register.
// Reset clears valid bits and loads the ball centers; payload is not reset.
// The whole pipeline holds while a finished word sits stalled at the output;
// cfg writes are taken at any time and should only land while idle.
module metaball_marching_squares_cell_top import mbms_pkg::*; #(
  parameter int unsigned CELL       = CELL_DEF,
  parameter int unsigned IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam int H = CELL / 2;

  logic en;

  // ball center registers
  logic [REG_W-1:0] ball_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) ball_q[i] <= REG_RESET[i];
    end else if (cfg_valid_i && (32'(cfg_index_i) < NUM_REGS)) begin
      ball_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // whole pipe advances unless the output word is held
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  // valid bits and cell coordinates alongside the lanes
  logic [LANE_LAT-1:0] vld_q;
  in_word_t            rc_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rc_q[0] <= in_data_i;
      for (int i = 1; i < LANE_LAT; i++) rc_q[i] <= rc_q[i-1];
    end
  end

  // corner k: 0 = a, 1 = c (col+S), 2 = b (row+S), 3 = d
  logic [ROOT_W-1:0] weight [NUM_CRN][NUM_BALLS];
  logic              zero   [NUM_CRN][NUM_BALLS];

  for (genvar k = 0; k < NUM_CRN; k++) begin : g_crn
    logic [CRD_W-1:0] crow, ccol;
    assign crow = CRD_W'(in_data_i.cell_row) + ((k >= 2) ? CRD_W'(CELL) : '0);
    assign ccol = CRD_W'(in_data_i.cell_col) + ((k % 2 == 1) ? CRD_W'(CELL) : '0);
    for (genvar b = 0; b < NUM_BALLS; b++) begin : g_ball
      mbms_lane #(
        .RADIUS(BALL_RADIUS[b])
      ) u_lane (
        .clk_i    (clk_i),
        .en_i     (en),
        .row_i    (crow),
        .col_i    (ccol),
        .ctr_row_i(signed'(ball_q[2*b])),
        .ctr_col_i(signed'(ball_q[2*b+1])),
        .zero_o   (zero[k][b]),
        .weight_o (weight[k][b])
      );
    end
  end

  // corner decision: field sum above one, or sitting on a center
  logic [CODE_W-1:0] code_d, code_q;
  logic              code_vld_q;
  in_word_t          code_rc_q;

  always_comb begin
    logic [WSUM_W-1:0] wsum;
    logic              hit;
    code_d = '0;
    for (int k = 0; k < NUM_CRN; k++) begin
      wsum = '0;
      hit  = 1'b0;
      for (int b = 0; b < NUM_BALLS; b++) begin
        wsum = wsum + WSUM_W'(weight[k][b]);
        hit  = hit | zero[k][b];
      end
      code_d[NUM_CRN-1-k] = hit || (wsum > ONE_FX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_vld_q <= 1'b0;
    end else if (en) begin
      code_vld_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q    <= code_d;
      code_rc_q <= rc_q[LANE_LAT-1];
    end
  end

  // fill mask with image bound clipping
  logic [CELL-1:0]   row_ok, col_ok;
  logic [MASK_W-1:0] mask_d;

  always_comb begin
    for (int i = 0; i < CELL; i++) begin
      row_ok[i] = (IMG_W'(code_rc_q.cell_row) + IMG_W'(i)) < IMG_W'(IMAGE_SIZE);
      col_ok[i] = (IMG_W'(code_rc_q.cell_col) + IMG_W'(i)) < IMG_W'(IMAGE_SIZE);
    end
    mask_d = '0;
    for (int x = 0; x < CELL; x++) begin
      for (int y = 0; y < CELL; y++) begin
        if (x * CELL + y < MASK_W) begin
          mask_d[x*CELL+y] = paint(code_q, x, y, CELL, H) && row_ok[x] && col_ok[y];
        end
      end
    end
  end

  logic      out_vld_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= code_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.corner_inside <= code_q;
      out_q.fill_mask     <= mask_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // pipe valid bits freeze while the output is held
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(code_vld_q))
    else $error("pipeline moved during output stall");

  // an accepted word enters the first lane stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word lost at entry");

  // a taken output with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !code_vld_q) |=> !out_valid_o)
    else $error("output word repeated");

endmodule
